FILE: design/kseqid_pkg.sv
// Shared types, sizes and codes for the keyed sequence id table.
package kseqid_pkg;

  localparam int ENTRIES    = 16;
  localparam int COUNT_BITS = 31;
  localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam int MODE_W  = 2;
  localparam int TAG_W   = 16;
  localparam int NODE_W  = 10;
  localparam int ENDS_W  = 2 * NODE_W;
  localparam int SIZE_W  = 32;
  localparam int ID_W    = 31;
  localparam int STAT_W  = 3;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // mode decode: high bit selects release, low bit selects the receive side
  localparam int MODE_REL_BIT  = 1;
  localparam int MODE_RECV_BIT = 0;

  typedef enum logic [STAT_W-1:0] {
    STAT_ISSUED    = 3'd0,
    STAT_KEPT      = 3'd1,
    STAT_FREED     = 3'd2,
    STAT_FULL      = 3'd3,
    STAT_UNKNOWN   = 3'd4,
    STAT_SATURATED = 3'd5
  } status_t;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [ENDS_W-1:0] ends;
    logic [SIZE_W-1:0] size;
  } key_t;

  // table update from the control path
  typedef struct packed {
    logic             alloc;
    logic             free;
    logic [IDX_W-1:0] idx;
  } cam_cmd_t;

  // lookup result back to the control path
  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic             avail;
    logic [IDX_W-1:0] free_idx;
  } cam_res_t;

endpackage

FILE: design/kseqid_cam.sv
// Key store with parallel compare and lowest-index hit / free-slot select.
module kseqid_cam (
  input  logic                 clk,
  input  logic                 rst_n,
  input  kseqid_pkg::key_t     key,
  input  kseqid_pkg::cam_cmd_t cmd,
  output kseqid_pkg::cam_res_t res
);
  import kseqid_pkg::*;

  logic [ENTRIES-1:0] valid_r;
  logic [TAG_W-1:0]   tag_r  [ENTRIES];
  logic [ENDS_W-1:0]  ends_r [ENTRIES];
  logic [SIZE_W-1:0]  size_r [ENTRIES];
  logic [ENTRIES-1:0] match;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid_r[i] && (tag_r[i] == key.tag) && (ends_r[i] == key.ends) &&
                 (size_r[i] == key.size);
    end
  end

  // lowest index wins
  always_comb begin
    res = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        res.hit     = 1'b1;
        res.hit_idx = IDX_W'(i);
      end
      if (!valid_r[i]) begin
        res.avail    = 1'b1;
        res.free_idx = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.alloc) begin
      valid_r[cmd.idx] <= 1'b1;
    end else if (cmd.free) begin
      valid_r[cmd.idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.alloc) begin
      tag_r[cmd.idx]  <= key.tag;
      ends_r[cmd.idx] <= key.ends;
      size_r[cmd.idx] <= key.size;
    end
  end

  a_alloc_sets: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.alloc |=> valid_r[$past(cmd.idx)])
    else $error("allocated entry not valid");

  a_free_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.free && !cmd.alloc |=> !valid_r[$past(cmd.idx)])
    else $error("released entry still valid");

  a_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    res.avail |-> !valid_r[res.free_idx])
    else $error("free slot points at a valid entry");

endmodule

FILE: design/keyed_sequence_id_table.sv
// Top level of the keyed sequence id table.
//
// Fully associative table of ENTRIES message keys (tag, source, destination,
// chunk size), each with a send and a receive counter. A send or receive
// request finds its key or takes the lowest free entry with both counts at
// zero, bumps that side's count and returns first_id plus the count before
// the bump. A release frees the entry only when both counts agree. Errors
// (table full, unknown key released, counter saturated) come back in status
// with a zero id. Every request gives exactly one result. A request is held in
// the input register, then is looked up, updated and written to the result
// register; one request can be taken every cycle while out_stall is low. The
// table update and the lookup of the following request meet at the same clock
// edge, so back-to-back requests on one key see each other's effect. The
// configuration port is always ready; first_id should only be changed while no
// request is in flight. Output back-pressure (out_stall) holds the result
// register and, once the input register is also full, raises in_stall.
module keyed_sequence_id_table (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [kseqid_pkg::MODE_W-1:0] in_mode,
  input  logic [kseqid_pkg::TAG_W-1:0]  in_msg_tag,
  input  logic [kseqid_pkg::NODE_W-1:0] in_source_node,
  input  logic [kseqid_pkg::NODE_W-1:0] in_dest_node,
  input  logic [kseqid_pkg::SIZE_W-1:0] in_chunk_bytes,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [kseqid_pkg::ID_W-1:0]   out_issued_id,
  output logic [kseqid_pkg::STAT_W-1:0] out_status,
  // configuration
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_first_id
);
  import kseqid_pkg::*;

  // configuration register
  logic first_id_r;

  // input register
  logic              s1_valid_r;
  logic [MODE_W-1:0] s1_mode_r;
  key_t              s1_key_r;

  // result register
  logic            out_valid_r;
  logic [ID_W-1:0] out_id_r;
  status_t         out_status_r;

  // counters, one pair per entry
  logic [COUNT_BITS-1:0] send_cnt_r [ENTRIES];
  logic [COUNT_BITS-1:0] recv_cnt_r [ENTRIES];

  logic                  advance;
  logic                  in_take;
  cam_cmd_t              cam_cmd;
  cam_res_t              cam_res;
  logic                  is_rel;
  logic                  is_recv;
  logic                  alloc;
  logic [IDX_W-1:0]      slot;
  logic [COUNT_BITS-1:0] send_cur;
  logic [COUNT_BITS-1:0] recv_cur;
  logic [COUNT_BITS-1:0] old_cnt;
  logic                  sat;
  logic                  cnt_we;
  logic [COUNT_BITS-1:0] send_nxt;
  logic [COUNT_BITS-1:0] recv_nxt;
  logic [COUNT_BITS-1:0] id_sum;
  logic [ID_W-1:0]       id_nxt;
  status_t               status_nxt;

  // --- handshakes ----------------------------------------------------------
  // the input register moves on when the result register is empty or is
  // being taken this cycle
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_id_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      first_id_r <= cfg_first_id;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_mode_r     <= in_mode;
      s1_key_r.tag  <= in_msg_tag;
      s1_key_r.ends <= {in_source_node, in_dest_node};
      s1_key_r.size <= in_chunk_bytes;
    end
  end

  // --- lookup --------------------------------------------------------------
  kseqid_cam u_cam (
    .clk   (clk),
    .rst_n (rst_n),
    .key   (s1_key_r),
    .cmd   (cam_cmd),
    .res   (cam_res)
  );

  // --- decision ------------------------------------------------------------
  assign is_rel  = s1_mode_r[MODE_REL_BIT];
  assign is_recv = s1_mode_r[MODE_RECV_BIT];
  assign alloc   = !is_rel && !cam_res.hit && cam_res.avail;
  assign slot    = cam_res.hit ? cam_res.hit_idx : cam_res.free_idx;

  // a fresh entry starts both counts at zero
  assign send_cur = alloc ? '0 : send_cnt_r[slot];
  assign recv_cur = alloc ? '0 : recv_cnt_r[slot];
  assign old_cnt  = is_recv ? recv_cur : send_cur;
  assign sat      = (old_cnt == COUNT_MAX);

  // non-saturated, so first_id + old count stays within COUNT_BITS
  assign id_sum = old_cnt + COUNT_BITS'(first_id_r);

  always_comb begin
    cam_cmd    = '0;
    cnt_we     = 1'b0;
    send_nxt   = send_cur;
    recv_nxt   = recv_cur;
    id_nxt     = '0;
    status_nxt = STAT_ISSUED;
    cam_cmd.idx = slot;
    if (is_rel) begin
      if (!cam_res.hit) begin
        status_nxt = STAT_UNKNOWN;
      end else if (send_cur == recv_cur) begin
        cam_cmd.free = advance;
        status_nxt   = STAT_FREED;
      end else begin
        status_nxt = STAT_KEPT;
      end
    end else if (!cam_res.hit && !cam_res.avail) begin
      status_nxt = STAT_FULL;
    end else begin
      // entry is allocated even when the count then saturates
      cam_cmd.alloc = advance && alloc;
      cnt_we        = advance;
      if (sat) begin
        status_nxt = STAT_SATURATED;
      end else begin
        if (is_recv) begin
          recv_nxt = recv_cur + COUNT_BITS'(1);
        end else begin
          send_nxt = send_cur + COUNT_BITS'(1);
        end
        id_nxt = ID_W'(id_sum);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      send_cnt_r[slot] <= send_nxt;
      recv_cnt_r[slot] <= recv_nxt;
    end
  end

  // --- result register -----------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_id_r     <= id_nxt;
      out_status_r <= status_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_issued_id = out_id_r;
  assign out_status    = out_status_r;

  // --- checks --------------------------------------------------------------
  a_err_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != STAT_ISSUED) |-> (out_id_r == '0))
    else $error("non-issue result carries an id");

  a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("transfer into result register lost");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r && out_stall && s1_valid_r)
    else $error("input stalled without back-pressure");

  a_alloc_free_only: assert property (@(posedge clk) disable iff (!rst_n)
    cam_cmd.alloc |-> !cam_res.hit && cam_res.avail && !is_rel)
    else $error("allocation without a free entry");

endmodule

FILE: verif/kseqid_checker.sv
// Checker for the keyed sequence id table: shadow table, expected-result queue and compare.
module kseqid_checker
  import kseqid_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [MODE_W-1:0] in_mode,
  input  logic [TAG_W-1:0]  in_msg_tag,
  input  logic [NODE_W-1:0] in_source_node,
  input  logic [NODE_W-1:0] in_dest_node,
  input  logic [SIZE_W-1:0] in_chunk_bytes,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [ID_W-1:0]   out_issued_id,
  input  logic [STAT_W-1:0] out_status,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic              cfg_first_id,
  output int                fail_count,
  output int                pending,
  output int                checked,
  output logic [5:0]        status_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ID_W-1:0] id;
    status_t         status;
  } id_result_t;

  logic                  first_id;
  logic                  ent_valid [ENTRIES];
  key_t                  ent_key   [ENTRIES];
  logic [COUNT_BITS-1:0] ent_sends [ENTRIES];
  logic [COUNT_BITS-1:0] ent_recvs [ENTRIES];
  id_result_t            expected_ids [$];

  int         errors = 0;
  int         results = 0;
  logic [5:0] seen = '0;

  // Look the key up, apply the request to the shadow table, return the result.
  function automatic id_result_t predict_request(logic [MODE_W-1:0] mode, key_t key);
    int                    hit;
    int                    free_slot;
    logic [COUNT_BITS-1:0] count;
    logic [32:0]           sum;
    id_result_t            r;
    hit = -1;
    free_slot = -1;
    r.id = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (ent_valid[i]) begin
        if (hit < 0 && ent_key[i] == key) hit = i;
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    if (mode[MODE_REL_BIT]) begin
      if (hit < 0) begin
        r.status = STAT_UNKNOWN;
      end else if (ent_sends[hit] == ent_recvs[hit]) begin
        ent_valid[hit] = 1'b0;
        r.status = STAT_FREED;
      end else begin
        r.status = STAT_KEPT;
      end
      return r;
    end
    if (hit < 0) begin
      if (free_slot < 0) begin
        r.status = STAT_FULL;
        return r;
      end
      hit = free_slot;
      ent_valid[hit] = 1'b1;
      ent_key[hit]   = key;
      ent_sends[hit] = '0;
      ent_recvs[hit] = '0;
    end
    count = mode[MODE_RECV_BIT] ? ent_recvs[hit] : ent_sends[hit];
    // allocation above stays even when the counter is full
    if (count == COUNT_MAX) begin
      r.status = STAT_SATURATED;
      return r;
    end
    count = count + 1'b1;
    if (mode[MODE_RECV_BIT]) ent_recvs[hit] = count;
    else ent_sends[hit] = count;
    sum = 33'(first_id) + 33'(count) - 33'd1;
    r.id = sum[ID_W-1:0];
    r.status = STAT_ISSUED;
    return r;
  endfunction

  always @(posedge clk) begin
    id_result_t want;
    key_t       key;
    if (!rst_n) begin
      first_id = 1'b0;
      for (int i = 0; i < ENTRIES; i++) ent_valid[i] = 1'b0;
      expected_ids.delete();
    end else begin
      // older transfers leave before the new request joins the queue
      if (out_valid && !out_stall) begin
        if (expected_ids.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual id %0d status %0d",
                   $time, out_issued_id, out_status);
        end else begin
          want = expected_ids.pop_front();
          results++;
          if (out_status < 6) seen[out_status] = 1'b1;
          if (out_issued_id !== want.id) begin
            errors++;
            $display("%0t: issued_id mismatch, expected %0d, actual %0d",
                     $time, want.id, out_issued_id);
          end
          if (out_status !== want.status) begin
            errors++;
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, out_status);
          end
        end
      end
      if (cfg_valid && cfg_ready) first_id = cfg_first_id;
      if (in_valid && !in_stall) begin
        key.tag  = in_msg_tag;
        key.ends = {in_source_node, in_dest_node};
        key.size = in_chunk_bytes;
        expected_ids.push_back(predict_request(in_mode, key));
      end
    end
    fail_count  <= errors;
    pending     <= expected_ids.size();
    checked     <= results;
    status_seen <= seen;
  end

endmodule

FILE: verif/tb_keyed_sequence_id_table.sv
// Testbench top for the keyed sequence id table: stimulus, back-pressure and verdict.
module tb_keyed_sequence_id_table;
  import kseqid_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // request modes; mode 3 decodes as a release as well
  localparam logic [MODE_W-1:0] MODE_SEND        = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RECV        = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RELEASE     = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RELEASE_ALT = 2'd3;

  localparam int POOL_KEYS    = 24;      // more keys than entries, so the table can fill
  localparam int RANDOM_ITEMS = 800;
  localparam int PHASE_ITEMS  = 200;     // first_id flips every this many requests
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [NODE_W-1:0] src;
    logic [NODE_W-1:0] dst;
    logic [SIZE_W-1:0] size;
  } msg_key_t;

  logic clk;
  logic rst_n = 1'b0;

  logic              in_valid       = 1'b0;
  logic [MODE_W-1:0] in_mode        = MODE_SEND;
  logic [TAG_W-1:0]  in_msg_tag     = '0;
  logic [NODE_W-1:0] in_source_node = '0;
  logic [NODE_W-1:0] in_dest_node   = '0;
  logic [SIZE_W-1:0] in_chunk_bytes = '0;
  logic              out_stall      = 1'b0;
  logic              cfg_valid      = 1'b0;
  logic              cfg_first_id   = 1'b0;

  logic              in_stall;
  logic              out_valid;
  logic [ID_W-1:0]   out_issued_id;
  logic [STAT_W-1:0] out_status;
  logic              cfg_ready;

  int         fail_count;
  int         pending;
  int         checked;
  logic [5:0] status_seen;

  // No idling on either side while this is set.
  logic quiet = 1'b0;

  // Stimulus-side bookkeeping: which pool keys hold an entry, and their send minus
  // receive balance. Used only to steer the stimulus clear of unwanted table-full.
  msg_key_t key_pool   [POOL_KEYS];
  int       balance    [POOL_KEYS];
  bit       resident   [POOL_KEYS];
  int       resident_count = 0;
  int       items_sent     = 0;
  int       cycle_count    = 0;
  int       phases         = 0;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  keyed_sequence_id_table DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_msg_tag     (in_msg_tag),
    .in_source_node (in_source_node),
    .in_dest_node   (in_dest_node),
    .in_chunk_bytes (in_chunk_bytes),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_issued_id  (out_issued_id),
    .out_status     (out_status),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_first_id   (cfg_first_id)
  );

  kseqid_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_msg_tag     (in_msg_tag),
    .in_source_node (in_source_node),
    .in_dest_node   (in_dest_node),
    .in_chunk_bytes (in_chunk_bytes),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_issued_id  (out_issued_id),
    .out_status     (out_status),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_first_id   (cfg_first_id),
    .fail_count     (fail_count),
    .pending        (pending),
    .checked        (checked),
    .status_seen    (status_seen)
  );

  // Result side back-pressure: out_stall is high on roughly 13 percent of cycles.
  always @(posedge clk) begin
    if (quiet) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 99) < 13);
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: run exceeded %0d cycles, %0d results still due",
               $time, CYCLE_LIMIT, pending);
      $display("tb: failure");
      $finish;
    end
  end

  // Fully random key; zero chunk size turns up now and then.
  function automatic msg_key_t random_key();
    msg_key_t k;
    k.tag  = TAG_W'($urandom);
    k.src  = NODE_W'($urandom);
    k.dst  = NODE_W'($urandom);
    k.size = ($urandom_range(0, 15) == 0) ? '0 : $urandom;
    return k;
  endfunction

  // Any pool key while there is room; only resident keys once the table is full.
  function automatic int pick_usable();
    int k;
    do begin
      k = $urandom_range(0, POOL_KEYS - 1);
    end while (resident_count == ENTRIES && !resident[k]);
    return k;
  endfunction

  // One request transfer, with an occasional idle gap before it. The payload holds
  // until the transfer happens; valid stays high straight into the next request.
  task automatic issue(input logic [MODE_W-1:0] mode, input msg_key_t key);
    if (!quiet && $urandom_range(0, 99) < 13) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_mode        <= mode;
    in_msg_tag     <= key.tag;
    in_source_node <= key.src;
    in_dest_node   <= key.dst;
    in_chunk_bytes <= key.size;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Request on a pool key, keeping the steering bookkeeping in step.
  task automatic pool_request(input logic [MODE_W-1:0] mode, input int k);
    issue(mode, key_pool[k]);
    if (mode[MODE_REL_BIT]) begin
      if (resident[k] && balance[k] == 0) begin
        resident[k] = 1'b0;
        resident_count--;
      end
    end else begin
      if (!resident[k]) begin
        resident[k] = 1'b1;
        resident_count++;
      end
      balance[k] += mode[MODE_RECV_BIT] ? -1 : 1;
    end
  endtask

  // Stop requests and wait until every result has come back.
  task automatic settle_table();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_first_id(input logic value);
    cfg_valid    <= 1'b1;
    cfg_first_id <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    phases++;
  endtask

  initial begin
    int   k;
    int   choice;
    int   n;
    int   sends;
    int   recvs;
    int   random_from;
    int   next_switch;
    logic id_base;

    // key 0 is all zeros (zero chunk size), key 1 all ones, the rest random
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_KEYS; i++) key_pool[i] = random_key();
    for (int i = 0; i < POOL_KEYS; i++) begin
      balance[i]  = 0;
      resident[i] = 1'b0;
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    write_first_id(1'b0);

    // Directed: unknown release, ids counting per side, a kept and a freed release,
    // mode 3 as release, extreme keys, then fill the table and ask for one more.
    pool_request(MODE_RELEASE, 2);
    pool_request(MODE_SEND, 2);
    pool_request(MODE_SEND, 2);
    pool_request(MODE_RECV, 2);
    pool_request(MODE_RELEASE, 2);
    pool_request(MODE_RECV, 2);
    pool_request(MODE_RELEASE_ALT, 2);
    pool_request(MODE_SEND, 0);
    pool_request(MODE_RECV, 1);
    for (int i = 0; i < POOL_KEYS && resident_count < ENTRIES; i++) begin
      if (!resident[i]) pool_request(MODE_SEND, i);
    end
    issue(MODE_SEND, random_key());          // table full
    pool_request(MODE_RELEASE_ALT, 0);       // open balance, entry kept
    settle_table();

    id_base = 1'b1;
    write_first_id(id_base);

    // Random: mostly balanced exchanges closed by a release, plus unbalanced
    // singles, stray releases, deliberate table-full bursts and key refreshes.
    random_from = items_sent;
    next_switch = random_from + PHASE_ITEMS;
    while (items_sent < random_from + RANDOM_ITEMS) begin
      if (items_sent >= next_switch) begin
        settle_table();
        id_base = ~id_base;
        write_first_id(id_base);
        next_switch += PHASE_ITEMS;
      end
      quiet <= (items_sent >= random_from + 300 && items_sent < random_from + 450);
      choice = $urandom_range(0, 99);
      if (choice < 70) begin
        k = pick_usable();
        n = $urandom_range(0, 3);
        sends = n + ((balance[k] < 0) ? -balance[k] : 0);
        recvs = n + ((balance[k] > 0) ? balance[k] : 0);
        while (sends + recvs > 0) begin
          if (recvs == 0 || (sends > 0 && $urandom_range(0, 1) == 1)) begin
            pool_request(MODE_SEND, k);
            sends--;
          end else begin
            pool_request(MODE_RECV, k);
            recvs--;
          end
        end
        pool_request(($urandom_range(0, 3) == 0) ? MODE_RELEASE_ALT : MODE_RELEASE, k);
      end else if (choice < 80) begin
        pool_request(($urandom_range(0, 1) == 1) ? MODE_RECV : MODE_SEND, pick_usable());
      end else if (choice < 88) begin
        pool_request(($urandom_range(0, 1) == 1) ? MODE_RELEASE_ALT : MODE_RELEASE,
                     $urandom_range(0, POOL_KEYS - 1));
      end else if (choice < 92) begin
        issue(MODE_RELEASE, random_key());
      end else if (choice < 95) begin
        // open keys until every entry is taken, then a fresh key must bounce
        while (resident_count < ENTRIES) begin
          do begin
            k = $urandom_range(0, POOL_KEYS - 1);
          end while (resident[k]);
          pool_request(MODE_SEND, k);
        end
        issue(($urandom_range(0, 1) == 1) ? MODE_RECV : MODE_SEND, random_key());
      end else begin
        k = $urandom_range(0, POOL_KEYS - 1);
        if (!resident[k]) key_pool[k] = random_key();
      end
    end

    quiet <= 1'b0;
    settle_table();
    repeat (4) @(posedge clk);

    $display("summary: %0d requests, %0d results checked, %0d first_id settings (0 and 1)",
             items_sent, checked, phases);
    $display("summary: status codes returned, one bit per code from 5 down to 0: %b",
             status_seen);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
